// ----- sv/irpfd_pkg.sv -----
// Shared types and constants of the IR pulse-distance frame decoder.
package irpfd_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [POS_W-1:0] FRAME_LEN  = 8'd139;
  localparam logic [POS_W-1:0] POS_SAT    = 8'd140;
  localparam logic [POS_W-1:0] FIRST_LO   = 8'd1;
  localparam logic [POS_W-1:0] FIRST_HI   = 8'd32;
  localparam logic [POS_W-1:0] BYTE_LO    = 8'd61;
  localparam logic [POS_W-1:0] BYTE_HI    = 8'd68;
  localparam logic [POS_W-1:0] SECOND_LO  = 8'd71;
  localparam logic [POS_W-1:0] SECOND_HI  = 8'd102;
  localparam logic [POS_W-1:0] TAIL_LO    = 8'd127;
  localparam logic [POS_W-1:0] TAIL_HI    = 8'd138;

  localparam logic [31:0] CHECK_MASK = 32'h00ff_ffff;

  localparam logic [DUR_W-1:0] LEADER_CENTER_RST = 16'd4500;
  localparam logic [DUR_W-1:0] LEADER_TOL_RST    = 16'd500;
  localparam logic [DUR_W-1:0] ONE_CENTER_RST    = 16'd1600;
  localparam logic [DUR_W-1:0] ONE_TOL_RST       = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_CENTER = 4'd0,
    REG_LEADER_TOL    = 4'd1,
    REG_ONE_CENTER    = 4'd2,
    REG_ONE_TOL       = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_LEADER  = 2'd1,
    ST_WRONG_COUNT = 2'd2,
    ST_MISMATCH    = 2'd3
  } status_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             frame_end;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [7:0]  byte_tail;
    logic [11:0] tail_bits;
  } out_word_t;

  typedef struct packed {
    logic [DUR_W-1:0] leader_center;
    logic [DUR_W-1:0] leader_tolerance;
    logic [DUR_W-1:0] one_center;
    logic [DUR_W-1:0] one_tolerance;
  } cfg_t;

endpackage

// ----- sv/irpfd_cfg.sv -----
// Configuration register file of the frame decoder.
module irpfd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [irpfd_pkg::DUR_W-1:0]      wr_data,
  output irpfd_pkg::cfg_t                  cfg
);

  irpfd_pkg::cfg_t cfg_r;
  irpfd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        irpfd_pkg::REG_LEADER_CENTER: cfg_nxt.leader_center    = wr_data;
        irpfd_pkg::REG_LEADER_TOL:    cfg_nxt.leader_tolerance = wr_data;
        irpfd_pkg::REG_ONE_CENTER:    cfg_nxt.one_center       = wr_data;
        irpfd_pkg::REG_ONE_TOL:       cfg_nxt.one_tolerance    = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_center    <= irpfd_pkg::LEADER_CENTER_RST;
      cfg_r.leader_tolerance <= irpfd_pkg::LEADER_TOL_RST;
      cfg_r.one_center       <= irpfd_pkg::ONE_CENTER_RST;
      cfg_r.one_tolerance    <= irpfd_pkg::ONE_TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/irpfd_core.sv -----
// Frame state, window classification and result formation for one duration.
module irpfd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  irpfd_pkg::in_word_t  item,
  input  irpfd_pkg::cfg_t      cfg,
  output irpfd_pkg::out_word_t result
);

  logic [irpfd_pkg::POS_W-1:0] position_r, position_nxt;
  logic                        leader_ok_r, leader_ok_nxt;
  logic [31:0]                 shift_first_r, shift_first_nxt;
  logic [31:0]                 shift_second_r, shift_second_nxt;
  logic [7:0]                  shift_byte_r, shift_byte_nxt;
  logic [11:0]                 shift_tail_r, shift_tail_nxt;

  logic [irpfd_pkg::DUR_W:0]   dur_x;
  logic [irpfd_pkg::DUR_W:0]   ldr_lo_x, ldr_hi_x, one_lo_x, one_hi_x;
  logic                        in_leader, bit_one;
  logic [irpfd_pkg::POS_W-1:0] count;
  logic [irpfd_pkg::POS_W-1:0] p;
  irpfd_pkg::status_t          status;

  // Windows compared as d + tol vs center and d vs center + tol: no wrap.
  assign dur_x    = {1'b0, item.duration};
  assign ldr_lo_x = dur_x + {1'b0, cfg.leader_tolerance};
  assign ldr_hi_x = {1'b0, cfg.leader_center} + {1'b0, cfg.leader_tolerance};
  assign one_lo_x = dur_x + {1'b0, cfg.one_tolerance};
  assign one_hi_x = {1'b0, cfg.one_center} + {1'b0, cfg.one_tolerance};

  assign in_leader = (ldr_lo_x >= {1'b0, cfg.leader_center}) && (dur_x <= ldr_hi_x);
  assign bit_one   = (one_lo_x > {1'b0, cfg.one_center}) && (dur_x < one_hi_x);

  assign p     = position_r;
  assign count = (p < irpfd_pkg::POS_SAT) ? p + 8'd1 : irpfd_pkg::POS_SAT;

  always_comb begin
    leader_ok_nxt    = leader_ok_r;
    shift_first_nxt  = shift_first_r;
    shift_second_nxt = shift_second_r;
    shift_byte_nxt   = shift_byte_r;
    shift_tail_nxt   = shift_tail_r;

    if (p == '0) begin
      leader_ok_nxt = in_leader;
    end else if (p >= irpfd_pkg::FIRST_LO && p <= irpfd_pkg::FIRST_HI) begin
      shift_first_nxt = {bit_one, shift_first_r[31:1]};
    end else if (p >= irpfd_pkg::BYTE_LO && p <= irpfd_pkg::BYTE_HI) begin
      shift_byte_nxt = {bit_one, shift_byte_r[7:1]};
    end else if (p >= irpfd_pkg::SECOND_LO && p <= irpfd_pkg::SECOND_HI) begin
      shift_second_nxt = {bit_one, shift_second_r[31:1]};
    end else if (p >= irpfd_pkg::TAIL_LO && p <= irpfd_pkg::TAIL_HI) begin
      shift_tail_nxt = {bit_one, shift_tail_r[11:1]};
    end

    if (!leader_ok_nxt) begin
      status = irpfd_pkg::ST_BAD_LEADER;
    end else if (count != irpfd_pkg::FRAME_LEN) begin
      status = irpfd_pkg::ST_WRONG_COUNT;
    end else if ((shift_first_nxt & irpfd_pkg::CHECK_MASK) !=
                 (shift_second_nxt & irpfd_pkg::CHECK_MASK)) begin
      status = irpfd_pkg::ST_MISMATCH;
    end else begin
      status = irpfd_pkg::ST_OK;
    end

    result.status = status;
    if (status == irpfd_pkg::ST_OK) begin
      result.word_first  = shift_first_nxt;
      result.word_second = shift_second_nxt;
      result.byte_tail   = shift_byte_nxt;
      result.tail_bits   = shift_tail_nxt;
    end else begin
      result.word_first  = '0;
      result.word_second = '0;
      result.byte_tail   = '0;
      result.tail_bits   = '0;
    end

    position_nxt = count;
    // Rearm after every frame end.
    if (item.frame_end) begin
      position_nxt     = '0;
      leader_ok_nxt    = 1'b0;
      shift_first_nxt  = '0;
      shift_second_nxt = '0;
      shift_byte_nxt   = '0;
      shift_tail_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      leader_ok_r    <= 1'b0;
      shift_first_r  <= '0;
      shift_second_r <= '0;
      shift_byte_r   <= '0;
      shift_tail_r   <= '0;
    end else if (step) begin
      position_r     <= position_nxt;
      leader_ok_r    <= leader_ok_nxt;
      shift_first_r  <= shift_first_nxt;
      shift_second_r <= shift_second_nxt;
      shift_byte_r   <= shift_byte_nxt;
      shift_tail_r   <= shift_tail_nxt;
    end
  end

endmodule

// ----- sv/ir_pulse_frame_decoder.sv -----
// Top level of the IR pulse-distance frame decoder: input stage, core and result register.
// Each input word is one measured space of a 139-space frame; the word with frame_end
// set produces one result word with a status (ok, bad leader, wrong count, check
// mismatch) and the four decoded fields, zero unless the status is ok. The block takes
// one input word per clock while in_stall is low: a word is registered on accept,
// classified against the leader and one windows from that input register, and when
// the core steps it is shifted into the frame state while a frame-end result lands
// in the output register and raises out_valid.
// Only the output register can hold up the flow, while a result sits unclaimed under
// out_stall and a further frame-end word is waiting. Configuration writes are taken at
// any time with cfg_ready held high and must be made only while the decoder is idle.
module ir_pulse_frame_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  irpfd_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output irpfd_pkg::out_word_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpfd_pkg::DUR_W-1:0]     cfg_data
);

  irpfd_pkg::cfg_t      cfg;
  irpfd_pkg::in_word_t  s1_word_r;
  logic                 s1_valid_r, s1_valid_nxt;
  irpfd_pkg::out_word_t out_word_r;
  logic                 out_valid_r, out_valid_nxt;
  irpfd_pkg::out_word_t result;
  logic                 out_free, s1_go, step, emit, in_take;

  assign cfg_ready = 1'b1;

  irpfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpfd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_word_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_free = !out_valid_r || !out_stall;
  // A word without frame end never needs the result register.
  assign s1_go    = !s1_word_r.frame_end || out_free;
  assign step     = s1_valid_r && s1_go;
  assign emit     = step && s1_word_r.frame_end;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (emit) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef NO_ASSERTIONS
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != irpfd_pkg::ST_OK |->
      out_data.word_first == '0 && out_data.word_second == '0 &&
      out_data.byte_tail == '0 && out_data.tail_bits == '0)
    else $error("failed frame carries nonzero fields");

  a_check_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == irpfd_pkg::ST_OK |->
      (out_data.word_first[23:0] == out_data.word_second[23:0]))
    else $error("ok status with mismatching check bits");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_word_r.frame_end && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("frame end word did not produce a result");
`endif

endmodule
